/* rtl/core/mvs_pkg.sv */
package mvs_pkg;

	// raw adc code width
	localparam int DATA_W = 16;
	// shared divider operand widths
	localparam int DVD_W = 32;
	localparam int DEN_W = 16;
	localparam int DIV_STEP_W = $clog2(DVD_W);

	// stream payload widths, padded to whole bytes
	localparam int IN_TDATA_W = 40;
	localparam int OUT_TDATA_W = 40;

	// configuration port
	localparam int CFG_ADDR_W = 3;

	// parameter defaults
	localparam int BLOCK_PAIRS_DEF = 16;
	localparam int LEARN_READS_DEF = 10;

	// register indexes
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_WATCH_LOW   = 3'd0,
		REG_WATCH_HIGH  = 3'd1,
		REG_OK_LOW      = 3'd2,
		REG_OK_HIGH     = 3'd3,
		REG_FAULT_LIMIT = 3'd4
	} cfg_idx_t;

	// function codes carried on tuser
	localparam logic FUNC_PAIR = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	localparam logic [DATA_W-1:0] CODE_MAX = '1;

	localparam logic [DATA_W-1:0] WATCH_LOW_RST   = '0;
	localparam logic [DATA_W-1:0] WATCH_HIGH_RST  = CODE_MAX;
	localparam logic [DATA_W-1:0] OK_LOW_RST      = '0;
	localparam logic [DATA_W-1:0] OK_HIGH_RST     = CODE_MAX;
	localparam logic [DATA_W-1:0] FAULT_LIMIT_RST = 16'd32;

	typedef struct packed {
		logic [DATA_W-1:0] watch_low;
		logic [DATA_W-1:0] watch_high;
		logic [DATA_W-1:0] ok_low;
		logic [DATA_W-1:0] ok_high;
		logic [DATA_W-1:0] fault_limit;
	} wdog_cfg_t;

	typedef struct packed {
		logic              step;
		logic [DATA_W-1:0] sample;
		logic [DATA_W-1:0] bus_mean;
	} wdog_req_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

/* rtl/core/mvs_div.sv */
// restoring divider, one quotient bit per cycle
module mvs_div import mvs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_STEP_W-1:0] step_q;
	logic [DVD_W-1:0]      dvd_q;
	logic [DEN_W-1:0]      den_q;
	logic [DEN_W-1:0]      rem_q;
	logic [DEN_W:0]        trial;
	logic                  fits;
	logic [DEN_W:0]        diff;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == DIV_STEP_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

/* rtl/core/mvs_wdog.sv */
// bus watchdog: event counter and sticky fault
module mvs_wdog import mvs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  wdog_cfg_t cfg,
	input  wdog_req_t req,
	output logic      fault
);

	logic [DATA_W-1:0] count_q;
	logic              latched_q;
	logic              outside;
	logic              bus_ok;
	logic [DATA_W-1:0] count_inc;
	logic [DATA_W-1:0] count_new;

	assign outside = (req.sample < cfg.watch_low) || (req.sample > cfg.watch_high);
	assign bus_ok  = (req.bus_mean > cfg.ok_low) && (req.bus_mean < cfg.ok_high);

	always_comb begin
		count_inc = (count_q == CODE_MAX) ? count_q : count_q + 1'b1;
		count_new = bus_ok ? '0 : count_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			latched_q <= 1'b0;
		end else if (req.step && outside) begin
			if (count_new > cfg.fault_limit) begin
				latched_q <= 1'b1;
				count_q   <= '0;
			end else begin
				count_q <= count_new;
			end
		end
	end

	assign fault = latched_q;

endmodule

/* rtl/core/motor_current_vbus_sense_conditioner.sv */
// motor current and bus voltage sense conditioner. each input beat is either an adc
// sample pair (tuser 0) or a read of the offset-corrected current mean (tuser 1);
// every input beat gives exactly one output beat. pairs are averaged per channel over
// BLOCK_PAIRS pairs; each finished current mean goes into a running sum and count
// unless the count is saturated; the bus mean is kept and reported on every output
// beat. a read divides sum by count, clears both, subtracts the learned offset
// (clamped at zero) and flags no_data when nothing was accumulated. the first
// LEARN_READS motor-off reads that find data set the offset. a bus sample outside the
// watch window counts an event, but an event while the bus mean sits strictly inside
// the ok window clears the count; a sticky fault latches once it exceeds fault_limit.
// timing: the block takes one beat at a time and drops tready from acceptance until
// its result is loaded into the output register. a pair not closing a block and a read
// with no data go straight to output, a pair closing a block first takes the current
// and then the bus mean, and a read waits for a radix-2 divider. the block means come
// from one multiply by the reciprocal of BLOCK_PAIRS, shared by the two channels,
// current first. while the output register still holds an untaken result, the next
// result waits in place until m_tready. the output register lets the next beat in
// while a result still waits for m_tready. configuration must be written by the user
// through cfg_we, cfg_addr and cfg_data only while the block is idle, which it does
// not enforce; indexes beyond the list are ignored.
module motor_current_vbus_sense_conditioner import mvs_pkg::*; #(
	parameter int BLOCK_PAIRS = BLOCK_PAIRS_DEF,
	parameter int LEARN_READS = LEARN_READS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [15:0] current_sample, [31:16] voltage_sample, [32] motor_enabled, [39:33] zero
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// [0] func
	input  logic                   s_tuser,
	// result stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [15:0] current_value, [31:16] bus_mean, [32] block_done, [33] no_data,
	// [34] fault, [35] offset_learning, [39:36] zero
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// configuration write port
	input  logic                   cfg_we,
	input  logic [CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [DATA_W-1:0]      cfg_data
);

	localparam int PIDX_W  = (BLOCK_PAIRS > 1) ? $clog2(BLOCK_PAIRS) : 1;
	localparam int BLK_SH  = $clog2(BLOCK_PAIRS);
	localparam int SUM_W   = DATA_W + BLK_SH;
	localparam int LEARN_W = $clog2(LEARN_READS + 1);

	// reciprocal of BLOCK_PAIRS, rounded up; exact for every block sum below 2**SUM_W
	localparam int RCP_SH = SUM_W + BLK_SH;
	localparam int RCP_W  = SUM_W + 2;
	localparam int PROD_W = SUM_W + RCP_W;
	localparam logic [RCP_W-1:0] RCP = RCP_W'(((64'd1 << RCP_SH) + 64'(BLOCK_PAIRS)
		- 64'd1) / 64'(BLOCK_PAIRS));

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CUR_MEAN,
		ST_VOL_MEAN,
		ST_RD_GO,
		ST_RD_WAIT,
		ST_OUT
	} state_t;

	state_t state_q;

	// configuration registers
	wdog_cfg_t cfg_q;

	// accumulation state
	logic [PIDX_W-1:0]  pair_idx_q;
	logic [SUM_W-1:0]   cur_sum_q;
	logic [SUM_W-1:0]   vol_sum_q;
	logic [DATA_W-1:0]  cur_mean_q;
	logic [DVD_W-1:0]   mean_sum_q;
	logic [DEN_W-1:0]   mean_cnt_q;
	logic [DATA_W-1:0]  bus_mean_q;
	logic [DATA_W-1:0]  offset_q;
	logic [LEARN_W-1:0] learn_cnt_q;

	// captured beat and pending result
	logic               motor_q;
	logic [DATA_W-1:0]  value_q;
	logic               done_flag_q;
	logic               no_data_q;

	// output register
	logic                   m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;

	// input field split
	logic              in_func;
	logic [DATA_W-1:0] in_cur;
	logic [DATA_W-1:0] in_vol;
	logic              in_motor;
	logic              in_fire;

	logic [SUM_W-1:0]  cur_sum_nx;
	logic [SUM_W-1:0]  vol_sum_nx;

	// block mean datapath
	logic [SUM_W-1:0]  blk_sum;
	logic [PROD_W-1:0] blk_prod;
	logic [DATA_W-1:0] blk_mean;

	// read datapath
	logic [DATA_W-1:0] rd_mean;
	logic              rd_learn;
	logic [DATA_W-1:0] rd_offset;

	div_req_t  div_req;
	div_rsp_t  div_rsp;
	wdog_req_t wd_req;
	logic      fault;
	logic      out_free;

	assign in_cur   = s_tdata[DATA_W-1:0];
	assign in_vol   = s_tdata[2*DATA_W-1:DATA_W];
	assign in_motor = s_tdata[2*DATA_W];
	assign in_func  = s_tuser;

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	assign cur_sum_nx = cur_sum_q + SUM_W'(in_cur);
	assign vol_sum_nx = vol_sum_q + SUM_W'(in_vol);

	// one multiplier serves both channels: current first, bus next
	assign blk_sum  = (state_q == ST_VOL_MEAN) ? vol_sum_q : cur_sum_q;
	assign blk_prod = PROD_W'(blk_sum) * PROD_W'(RCP);
	assign blk_mean = blk_prod[RCP_SH +: DATA_W];

	// divider only runs the read mean
	assign div_req.start    = (state_q == ST_RD_GO);
	assign div_req.dividend = mean_sum_q;
	assign div_req.divisor  = mean_cnt_q;

	mvs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// watchdog sees the bus mean from before this pair
	assign wd_req.step     = in_fire && (in_func == FUNC_PAIR);
	assign wd_req.sample   = in_vol;
	assign wd_req.bus_mean = bus_mean_q;

	mvs_wdog u_wdog (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.req    (wd_req),
		.fault  (fault)
	);

	// offset learning and correction
	assign rd_mean   = div_rsp.quotient[DATA_W-1:0];
	assign rd_learn  = (learn_cnt_q < LEARN_W'(LEARN_READS)) && !motor_q;
	assign rd_offset = rd_learn ? rd_mean : offset_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.watch_low   <= WATCH_LOW_RST;
			cfg_q.watch_high  <= WATCH_HIGH_RST;
			cfg_q.ok_low      <= OK_LOW_RST;
			cfg_q.ok_high     <= OK_HIGH_RST;
			cfg_q.fault_limit <= FAULT_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_addr))
				REG_WATCH_LOW:   cfg_q.watch_low   <= cfg_data;
				REG_WATCH_HIGH:  cfg_q.watch_high  <= cfg_data;
				REG_OK_LOW:      cfg_q.ok_low      <= cfg_data;
				REG_OK_HIGH:     cfg_q.ok_high     <= cfg_data;
				REG_FAULT_LIMIT: cfg_q.fault_limit <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer, accumulation state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pair_idx_q  <= '0;
			cur_sum_q   <= '0;
			vol_sum_q   <= '0;
			cur_mean_q  <= '0;
			mean_sum_q  <= '0;
			mean_cnt_q  <= '0;
			bus_mean_q  <= '0;
			offset_q    <= '0;
			learn_cnt_q <= '0;
			m_valid_q   <= 1'b0;
			motor_q     <= 1'b0;
			value_q     <= '0;
			done_flag_q <= 1'b0;
			no_data_q   <= 1'b0;
			m_data_q    <= '0;
		end else begin
			// load the result once the output register is free
			if ((state_q == ST_OUT) && out_free) begin
				m_valid_q <= 1'b1;
				m_data_q  <= {
					4'b0000,
					learn_cnt_q < LEARN_W'(LEARN_READS),
					fault,
					no_data_q,
					done_flag_q,
					bus_mean_q,
					value_q
				};
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						motor_q     <= in_motor;
						value_q     <= '0;
						done_flag_q <= 1'b0;
						no_data_q   <= 1'b0;
						if (in_func == FUNC_PAIR) begin
							cur_sum_q <= cur_sum_nx;
							vol_sum_q <= vol_sum_nx;
							if (pair_idx_q == PIDX_W'(BLOCK_PAIRS - 1)) begin
								// block closes: average both sums
								pair_idx_q <= '0;
								state_q    <= ST_CUR_MEAN;
							end else begin
								pair_idx_q <= pair_idx_q + 1'b1;
								state_q    <= ST_OUT;
							end
						end else if (mean_cnt_q == '0) begin
							no_data_q <= 1'b1;
							state_q   <= ST_OUT;
						end else begin
							state_q <= ST_RD_GO;
						end
					end
				end
				ST_CUR_MEAN: begin
					cur_mean_q <= blk_mean;
					cur_sum_q  <= '0;
					state_q    <= ST_VOL_MEAN;
				end
				ST_VOL_MEAN: begin
					// saturated count drops the block mean
					if (mean_cnt_q != CODE_MAX) begin
						mean_sum_q <= mean_sum_q + DVD_W'(cur_mean_q);
						mean_cnt_q <= mean_cnt_q + 1'b1;
					end
					bus_mean_q  <= blk_mean;
					vol_sum_q   <= '0;
					done_flag_q <= 1'b1;
					state_q     <= ST_OUT;
				end
				ST_RD_GO: begin
					state_q <= ST_RD_WAIT;
				end
				ST_RD_WAIT: begin
					if (div_rsp.done) begin
						mean_sum_q <= '0;
						mean_cnt_q <= '0;
						if (rd_learn) begin
							offset_q    <= rd_mean;
							learn_cnt_q <= learn_cnt_q + 1'b1;
						end
						value_q <= (rd_mean >= rd_offset) ? rd_mean - rd_offset : '0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

/* rtl/core/mvs_chk.sv */
// port-level checks for the sense conditioner
module mvs_chk import mvs_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	// fault seen on a delivered beat
	logic fault_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_seen_q <= 1'b0;
		end else if (m_tvalid && m_tready && m_tdata[34]) begin
			fault_seen_q <= 1'b1;
		end
	end

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// one beat at a time: busy right after acceptance
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while previous beat in work");

	// fault is sticky across results
	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && fault_seen_q |-> m_tdata[34])
		else $error("fault flag dropped");

	// a pair result and a read flag never mix
	a_done_vs_nodata: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[32] && m_tdata[33]))
		else $error("block_done and no_data both set");

	// empty read gives zero current
	a_nodata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[33] |-> m_tdata[15:0] == '0)
		else $error("no_data read with nonzero current");

endmodule

bind motor_current_vbus_sense_conditioner mvs_chk u_mvs_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

/* tb/sense_reading_checker.sv */
`timescale 1ns / 1ps

module sense_reading_checker import mvs_pkg::*; #(
	parameter int BLOCK_PAIRS = BLOCK_PAIRS_DEF,
	parameter int LEARN_READS = LEARN_READS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   s_tuser,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_we,
	input  logic [CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [DATA_W-1:0]      cfg_data,
	output int                     mismatch_count,
	output int                     readings_in_flight,
	output int                     readings_checked
);

	typedef struct packed {
		logic [DATA_W-1:0] current_value;
		logic [DATA_W-1:0] bus_mean;
		logic              block_done;
		logic              no_data;
		logic              fault;
		logic              offset_learning;
	} reading_t;

	reading_t pending_readings[$];

	// register copies
	logic [DATA_W-1:0] watch_low, watch_high, ok_low, ok_high, fault_limit;

	// conditioner state
	int                pairs_in_block;
	logic [19:0]       cur_block_sum;
	logic [19:0]       bus_block_sum;
	logic [31:0]       mean_total;
	logic [DATA_W-1:0] means_held;
	logic [DATA_W-1:0] bus_avg;
	logic [DATA_W-1:0] cur_offset;
	int                offset_reads;
	logic [DATA_W-1:0] wd_events;
	logic              fault_sticky;

	function automatic reading_t condition_beat(input logic func, input logic [DATA_W-1:0] cs,
			input logic [DATA_W-1:0] vs, input logic motor);
		reading_t r;
		logic [31:0] q;
		logic [DATA_W-1:0] m;
		r = '0;
		if (func == FUNC_PAIR) begin
			// watchdog sees the bus mean from before this pair
			if (vs < watch_low || vs > watch_high) begin
				if (wd_events != CODE_MAX)
					wd_events = wd_events + 1'b1;
				if (bus_avg > ok_low && bus_avg < ok_high)
					wd_events = '0;
				if (wd_events > fault_limit) begin
					fault_sticky = 1'b1;
					wd_events = '0;
				end
			end
			cur_block_sum = cur_block_sum + cs;
			bus_block_sum = bus_block_sum + vs;
			pairs_in_block++;
			if (pairs_in_block >= BLOCK_PAIRS) begin
				q = 32'(cur_block_sum) / 32'(BLOCK_PAIRS);
				if (means_held != CODE_MAX) begin
					mean_total = mean_total + q[DATA_W-1:0];
					means_held = means_held + 1'b1;
				end
				q = 32'(bus_block_sum) / 32'(BLOCK_PAIRS);
				bus_avg = q[DATA_W-1:0];
				cur_block_sum = '0;
				bus_block_sum = '0;
				pairs_in_block = 0;
				r.block_done = 1'b1;
			end
		end else begin
			if (means_held == '0) begin
				r.no_data = 1'b1;
			end else begin
				q = mean_total / {16'd0, means_held};
				m = q[DATA_W-1:0];
				mean_total = '0;
				means_held = '0;
				if (offset_reads < LEARN_READS && !motor) begin
					cur_offset = m;
					offset_reads++;
				end
				r.current_value = (m >= cur_offset) ? m - cur_offset : '0;
			end
		end
		r.bus_mean = bus_avg;
		r.fault = fault_sticky;
		r.offset_learning = (offset_reads < LEARN_READS);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	task automatic compare_reading(input reading_t want, input logic [OUT_TDATA_W-1:0] got);
		check_field("current_value", want.current_value, got[15:0]);
		check_field("bus_mean", want.bus_mean, got[31:16]);
		check_field("block_done", want.block_done, got[32]);
		check_field("no_data", want.no_data, got[33]);
		check_field("fault", want.fault, got[34]);
		check_field("offset_learning", want.offset_learning, got[35]);
		check_field("tdata padding", '0, got[OUT_TDATA_W-1:36]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			watch_low = WATCH_LOW_RST;
			watch_high = WATCH_HIGH_RST;
			ok_low = OK_LOW_RST;
			ok_high = OK_HIGH_RST;
			fault_limit = FAULT_LIMIT_RST;
			pairs_in_block = 0;
			cur_block_sum = '0;
			bus_block_sum = '0;
			mean_total = '0;
			means_held = '0;
			bus_avg = '0;
			cur_offset = '0;
			offset_reads = 0;
			wd_events = '0;
			fault_sticky = 1'b0;
			pending_readings.delete();
			readings_in_flight <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_WATCH_LOW:   watch_low = cfg_data;
					REG_WATCH_HIGH:  watch_high = cfg_data;
					REG_OK_LOW:      ok_low = cfg_data;
					REG_OK_HIGH:     ok_high = cfg_data;
					REG_FAULT_LIMIT: fault_limit = cfg_data;
					default: ;
				endcase
			end
			// take the result first so a beat entering this edge cannot mask a stray one
			if (m_tvalid && m_tready) begin
				if (pending_readings.size() == 0) begin
					$display("%0t: result with nothing pending, expected none actual %h",
						$time, m_tdata);
					mismatch_count++;
				end else begin
					compare_reading(pending_readings.pop_front(), m_tdata);
					readings_checked++;
				end
			end
			if (s_tvalid && s_tready)
				pending_readings.push_back(condition_beat(s_tuser, s_tdata[15:0],
					s_tdata[31:16], s_tdata[32]));
			readings_in_flight <= pending_readings.size();
		end
	end

endmodule

/* tb/tb_motor_current_vbus_sense_conditioner.sv */
`timescale 1ns / 1ps

module tb_motor_current_vbus_sense_conditioner;
	import mvs_pkg::*;

	// a read is the slowest beat
	localparam int QUIET_LIMIT = 2000;
	// long output stall used to back the block up into its input
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 200;
	localparam int RANDOM_BEATS = 260;
	// pairs that keep raising the watchdog event count without clearing it
	localparam int CLIMB_PAIRS = 200;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   s_tuser = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
	logic [DATA_W-1:0]      cfg_data = '0;

	int mismatch_count;
	int readings_in_flight;
	int readings_checked;

	// stimulus knobs; idle_on and hold_pending are shared between the sender and the receiver
	bit   idle_on = 1'b1;
	bit   hold_pending = 1'b0;
	int   v_lo = 0;
	int   v_hi = 65535;
	logic [DATA_W-1:0] set_watch_low = WATCH_LOW_RST;
	logic [DATA_W-1:0] set_watch_high = WATCH_HIGH_RST;

	int beats_sent = 0;
	int settings_applied = 0;
	int quiet_cycles = 0;

	motor_current_vbus_sense_conditioner i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		// [15:0] current_sample, [31:16] voltage_sample, [32] motor_enabled, [39:33] zero
		.s_tdata  (s_tdata),
		// [0] func
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		// [15:0] current_value, [31:16] bus_mean, [32] block_done, [33] no_data,
		// [34] fault, [35] offset_learning, [39:36] zero
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	sense_reading_checker i_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.s_tvalid           (s_tvalid),
		.s_tready           (s_tready),
		.s_tdata            (s_tdata),
		.s_tuser            (s_tuser),
		.m_tvalid           (m_tvalid),
		.m_tready           (m_tready),
		.m_tdata            (m_tdata),
		.cfg_we             (cfg_we),
		.cfg_addr           (cfg_addr),
		.cfg_data           (cfg_data),
		.mismatch_count     (mismatch_count),
		.readings_in_flight (readings_in_flight),
		.readings_checked   (readings_checked)
	);

	always #10 clk = ~clk;

	// one input beat; valid stays high across back-to-back beats when no gap is drawn
	task automatic send_beat(input logic func, input logic [DATA_W-1:0] cs,
			input logic [DATA_W-1:0] vs, input logic motor);
		int gap;
		gap = idle_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= {7'b0, motor, vs, cs};
		do @(posedge clk); while (!s_tready);
		beats_sent++;
	endtask

	// mostly pairs so blocks complete between reads; bus codes cluster on the watch edges
	task automatic send_random_beat(input int read_pct);
		logic func;
		logic [DATA_W-1:0] cs;
		int code;
		func = ($urandom_range(0, 99) < read_pct) ? FUNC_READ : FUNC_PAIR;
		case ($urandom_range(0, 9))
			0: cs = '0;
			1: cs = '1;
			default: cs = $urandom_range(0, 65535);
		endcase
		case ($urandom_range(0, 7))
			0: code = v_lo;
			1: code = v_hi;
			2: code = int'(set_watch_low) + int'($urandom_range(0, 2)) - 1;
			3: code = int'(set_watch_high) + int'($urandom_range(0, 2)) - 1;
			default: code = $urandom_range(v_lo, v_hi);
		endcase
		if (code < v_lo)
			code = v_lo;
		if (code > v_hi)
			code = v_hi;
		send_beat(func, cs, code[DATA_W-1:0], 1'($urandom_range(0, 1)));
	endtask

	// stop offering and wait until every outstanding result has been taken
	task automatic drain_readings();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (readings_in_flight != 0);
	endtask

	// the block is idle once drained; all five registers are written back to back
	task automatic apply_settings(input logic [DATA_W-1:0] wl, input logic [DATA_W-1:0] wh,
			input logic [DATA_W-1:0] okl, input logic [DATA_W-1:0] okh,
			input logic [DATA_W-1:0] lim);
		drain_readings();
		cfg_we <= 1'b1;
		cfg_addr <= REG_WATCH_LOW;
		cfg_data <= wl;
		@(posedge clk);
		cfg_addr <= REG_WATCH_HIGH;
		cfg_data <= wh;
		@(posedge clk);
		cfg_addr <= REG_OK_LOW;
		cfg_data <= okl;
		@(posedge clk);
		cfg_addr <= REG_OK_HIGH;
		cfg_data <= okh;
		@(posedge clk);
		cfg_addr <= REG_FAULT_LIMIT;
		cfg_data <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
		set_watch_low = wl;
		set_watch_high = wh;
		settings_applied++;
	endtask

	function automatic logic [DATA_W-1:0] draw_setting();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return DATA_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// receiver: random stalls per beat, plus one long hold on request
	initial begin
		int wait_cycles;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_pending) begin
				hold_pending = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			wait_cycles = idle_on ? $urandom_range(0, 4) : 0;
			if (wait_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	// watchdog on accepted beats and register writes
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int i;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part on reset settings
		// read before any block finished: no data
		send_beat(FUNC_READ, '0, '0, 1'b0);
		// one full block of alternating extremes on both channels, means land mid scale
		for (i = 0; i < 16; i++)
			send_beat(FUNC_PAIR, i[0] ? 16'h0000 : 16'hFFFF, i[0] ? 16'hFFFF : 16'h0000, i[0]);
		// read with the motor running: returns the mean, offset stays unlearned
		send_beat(FUNC_READ, '1, '1, 1'b1);
		// sum and count were cleared by that read
		send_beat(FUNC_READ, '1, '0, 1'b0);

		// narrow watch window, zero fault limit; the bus mean always sits inside the ok
		// window so every event clears the count and the fault must not latch.
		// offset learning proceeds here as motor-off reads come along
		apply_settings(16'd20000, 16'd45000, 16'h0000, 16'hFFFF, 16'h0000);
		v_lo = 1000;
		v_hi = 64000;
		repeat (RANDOM_BEATS) send_random_beat(10);

		// every pair is a watchdog event and nothing clears the count: it keeps climbing
		// while the limit sits at full scale
		apply_settings('1, '1, '1, '0, '1);
		idle_on = 1'b0;
		for (i = 0; i < CLIMB_PAIRS; i++) begin
			send_beat(FUNC_PAIR, DATA_W'($urandom_range(0, 65535)),
				DATA_W'($urandom_range(0, 65534)), 1'($urandom_range(0, 1)));
			if (i % 50 == 49)
				send_beat(FUNC_READ, '0, '0, 1'($urandom_range(0, 1)));
		end

		// limit below the count reached: the next event latches the fault
		apply_settings('1, '1, '1, '0, 16'd150);
		repeat (3)
			send_beat(FUNC_PAIR, DATA_W'($urandom_range(0, 65535)),
				DATA_W'($urandom_range(0, 65534)), 1'($urandom_range(0, 1)));

		// random settings, one phase pinned to register extremes, one without idling,
		// one with a long receiver hold while the sender keeps offering
		v_lo = 0;
		v_hi = 65535;
		for (int k = 0; k < 5; k++) begin
			if (k == 1)
				apply_settings('0, '0, '1, '0, '0);
			else
				apply_settings(draw_setting(), draw_setting(), draw_setting(), draw_setting(),
					draw_setting());
			idle_on = (k != 4);
			for (int n = 0; n < RANDOM_BEATS; n++) begin
				if (k == 2 && n == 100)
					hold_pending = 1'b1;
				send_random_beat(8);
			end
		end

		drain_readings();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d beats over %0d register settings, %0d results checked",
			beats_sent, settings_applied, readings_checked);
		$display("offset learning, watchdog clearing, event count climb and fault latch");
		if (mismatch_count == 0 && readings_in_flight == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/mvs_pkg.sv
rtl/core/mvs_div.sv
rtl/core/mvs_wdog.sv
rtl/core/motor_current_vbus_sense_conditioner.sv
rtl/core/mvs_chk.sv
tb/sense_reading_checker.sv
tb/tb_motor_current_vbus_sense_conditioner.sv
